// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They sample on clk_i and are held off
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, prop)
`define ASSERT_NEVER(label, expr)

`endif

`endif

// File: src/fsmatch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First substring match package
// Types, codes and defaults shared by the match cells and the top level.
// ----------------------------------------------------------------------------
package fsmatch_pkg;

  // Default sizes.
  localparam int unsigned     MaxPatternDef = 64;
  localparam logic [32:0]     MaxTextDef    = 33'd65536;

  // Fixed field widths.
  localparam int unsigned CountW = 17;
  localparam int unsigned PosW   = 16;

  typedef logic [7:0] byte_t;

  // Request operation codes.
  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_SHORT     = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic text_en;  // a text byte is compared and the chain advances
    logic clear;    // partial-match bits return to zero
  } cell_ctrl_t;

endpackage

// File: src/fsmatch_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First substring match cell
// Holds one pattern byte and one partial-match bit. On each text byte the
// bit takes the neighbor's bit when the stored byte equals the text byte.
// ----------------------------------------------------------------------------
module fsmatch_cell import fsmatch_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       load_i,    // this cell takes the pattern byte
  input  logic       active_i,  // this cell lies inside the pattern
  input  byte_t      value_i,
  input  logic       match_i,   // partial-match bit of the left neighbor
  output logic       match_o,   // registered partial-match bit
  output logic       next_o     // bit that the current text byte produces
);

  byte_t pat_q;
  logic  pm_q, pm_d;

  // The new bit extends the neighbor's partial match by one byte.
  assign next_o = match_i & active_i & (pat_q == value_i);

  always_comb begin
    pm_d = pm_q;
    if (ctrl_i.clear) begin
      pm_d = 1'b0;
    end else if (ctrl_i.text_en) begin
      pm_d = next_o;
    end
  end

  // Pattern byte storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q <= 1'b0;
    end else begin
      pm_q <= pm_d;
    end
  end

  assign match_o = pm_q;

endmodule

// File: src/first_substring_match_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First substring match core
// Searches a streamed text for the first occurrence of a stored pattern.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the in channel (in_valid_i, in_stall_o). A request with
// operation 0 loads one pattern byte; last marks the final pattern byte. The
// pattern stays stored, and a pattern byte after a finished pattern starts a
// new one. A request with operation 1 feeds one text byte; text bytes are
// dropped while no finished pattern exists. The text byte marked last
// produces one result (status, position) on the out channel (out_valid_o,
// out_stall_i) in the cycle after it is accepted.
// A text byte is broadcast along a row of MaxPattern cells, each comparing
// its pattern byte and passing its partial-match bit to the next cell, so
// a byte is accepted every cycle while in_stall_o is low.
// The single output register holds a result while out_stall_i is high; in
// that time in_stall_o is high too. Reset clears the pattern length, flags,
// partial-match bits and out_valid_o, but not pattern bytes or the result.
// ----------------------------------------------------------------------------
module first_substring_match_core import fsmatch_pkg::*; #(
  parameter int unsigned MaxPattern = MaxPatternDef,
  parameter logic [32:0] MaxText    = MaxTextDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            operation_i,
  input  logic [7:0]      value_i,
  input  logic            last_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      status_o,
  output logic [PosW-1:0] position_o
);

  `include "assert_macros.svh"

  localparam int unsigned LenW     = $clog2(MaxPattern + 1);
  localparam logic [32:0] PosLimit = (MaxText > 33'd65536) ? 33'd65536 : MaxText;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Pattern and text state.
  logic [LenW-1:0]   len_q, len_d;
  logic              done_q, done_d;
  logic              ovf_q, ovf_d;
  logic [CountW-1:0] count_q, count_d;
  logic              found_q, found_d;
  logic [PosW-1:0]   mpos_q, mpos_d;

  // Output register.
  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic [PosW-1:0] pos_q, pos_d;

  logic            accept, is_text, text_step, emit;
  logic [LenW-1:0] eff_len, top;
  logic            hit, record;
  logic [CountW-1:0] count_inc, cand_pos;
  cell_ctrl_t      ctrl;

  logic [MaxPattern-1:0] pm, next_bits, active, load, is_top, chain_in;

  // The input waits only while a result sits in a stalled output register.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_text    = (op_e'(operation_i) == OP_TEXT);
  assign text_step  = accept & is_text & done_q;
  assign emit       = text_step & last_i;

  // A byte after a finished pattern starts a new one at index zero.
  assign eff_len = done_q ? '0 : len_q;
  assign top     = len_q - LenW'(1);

  assign ctrl.text_en = text_step;
  assign ctrl.clear   = (accept & ~is_text) | emit;

  // Row of cells, each fed by its left neighbor; the first cell gets a one.
  for (genvar i = 0; i < MaxPattern; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign chain_in[i] = 1'b1;
    end else begin : g_body
      assign chain_in[i] = pm[i-1];
    end
    assign active[i] = (LenW'(i) < len_q);
    assign is_top[i] = (LenW'(i) == top) & (len_q != '0);
    assign load[i]   = accept & ~is_text & (eff_len == LenW'(i));

    fsmatch_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .load_i   (load[i]),
      .active_i (active[i]),
      .value_i  (value_i),
      .match_i  (chain_in[i]),
      .match_o  (pm[i]),
      .next_o   (next_bits[i])
    );
  end

  // Full match when the bit of the last pattern byte comes up.
  assign hit       = |(next_bits & is_top);
  assign cand_pos  = (count_q >= CountW'(top)) ? (count_q - CountW'(top)) : '0;
  assign record    = hit & ~found_q & (33'(cand_pos) < PosLimit);
  assign count_inc = (count_q == CountMax) ? count_q : (count_q + CountW'(1));

  // Next state of the pattern, text and result.
  always_comb begin
    len_d       = len_q;
    done_d      = done_q;
    ovf_d       = ovf_q;
    count_d     = count_q;
    found_d     = found_q;
    mpos_d      = mpos_q;
    out_valid_d = out_valid_q & out_stall_i;
    status_d    = status_q;
    pos_d       = pos_q;
    if (accept && !is_text) begin
      // Pattern byte: clears the text, stores or overflows.
      done_d  = last_i;
      count_d = '0;
      found_d = 1'b0;
      mpos_d  = '0;
      if (32'(eff_len) < MaxPattern) begin
        len_d = eff_len + LenW'(1);
        ovf_d = done_q ? 1'b0 : ovf_q;
      end else begin
        len_d = eff_len;
        ovf_d = 1'b1;
      end
    end else if (text_step) begin
      count_d = count_inc;
      if (record) begin
        found_d = 1'b1;
        mpos_d  = cand_pos[PosW-1:0];
      end
      if (last_i) begin
        out_valid_d = 1'b1;
        pos_d       = '0;
        if (ovf_q) begin
          status_d = ST_OVERFLOW;
        end else if (CountW'(len_q) > count_inc) begin
          status_d = ST_SHORT;
        end else if (found_d) begin
          status_d = ST_FOUND;
          pos_d    = mpos_d;
        end else begin
          status_d = ST_NOT_FOUND;
        end
        count_d = '0;
        found_d = 1'b0;
        mpos_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      done_q      <= 1'b0;
      ovf_q       <= 1'b0;
      count_q     <= '0;
      found_q     <= 1'b0;
      mpos_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      done_q      <= done_d;
      ovf_q       <= ovf_d;
      count_q     <= count_d;
      found_q     <= found_d;
      mpos_q      <= mpos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign position_o  = pos_q;

  // A final text byte always leaves a result in the output register.
  `ASSERT_PROP(a_emit_result, emit |=> out_valid_q)
  // Only a found result carries a nonzero position.
  `ASSERT_NEVER(a_pos_zero, out_valid_q && (status_q != ST_FOUND) && (pos_q != '0))
  // Partial-match bits never sit outside the stored pattern.
  `ASSERT_NEVER(a_pm_inside, (pm & ~active) != '0)
  // Overflow only happens with a full pattern store.
  `ASSERT_PROP(a_ovf_full, ovf_q |-> (32'(len_q) == MaxPattern))
  // A recorded match belongs to a finished pattern.
  `ASSERT_PROP(a_found_done, found_q |-> done_q)

endmodule
